// ===== hw/rtl/adcwu_pkg.sv =====
// Package for the digitiser word unpacker with timestamp unwrapping.
// Holds sizes, codes and the structs passed between the adcwu modules.
// Depends on nothing.
`default_nettype none

package adcwu_pkg;

  localparam int NumBoards   = 3;
  localparam int NumChannels = 8;
  localparam int SlotCount   = NumBoards * NumChannels;
  localparam int SlotW       = $clog2(SlotCount);

  localparam int StampW   = 28;
  localparam int WrapW    = 24;
  localparam int EntryW   = 16;
  localparam int ExtW     = WrapW + StampW;
  localparam int SampleW  = 13;
  localparam int TimeW    = 61;
  localparam int ChanW    = 3;
  localparam int BoardW   = 2;
  localparam int CodeW    = 8;
  localparam int FilterW  = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 80;
  localparam int InUserW  = CodeW + ChanW;
  localparam int OutDataW = 80;
  localparam int OutUserW = ChanW + BoardW;

  // Backward jump that counts as a wrap: 0.95 * 2^28, truncated.
  localparam logic [StampW-1:0] WrapJump  = StampW'(255013683);
  localparam logic [WrapW-1:0]  WrapMax   = '1;
  localparam logic [EntryW-1:0] EntryMax  = '1;
  localparam logic [FilterW-1:0] FilterAll = '1;
  localparam logic [EntryW-1:0] MinEntriesReset = EntryW'(300);

  localparam logic [CodeW-1:0] BoardCode16  = 8'd16;
  localparam logic [CodeW-1:0] BoardCode64  = 8'd64;
  localparam logic [CodeW-1:0] BoardCode128 = 8'd128;

  localparam logic [BoardW-1:0] BoardIdx16  = 2'd0;
  localparam logic [BoardW-1:0] BoardIdx64  = 2'd1;
  localparam logic [BoardW-1:0] BoardIdx128 = 2'd2;

  localparam logic [1:0] BeatLast = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    RegChanFilter = 2'd0,
    RegMinEntries = 2'd1
  } cfg_reg_e;

  // Unpacked word; samples[0] is A1, then B1, A0, B0.
  typedef struct packed {
    logic [StampW-1:0]             stamp;
    logic [3:0][SampleW-1:0]       samples;
    logic [ChanW-1:0]              chan;
    logic [BoardW-1:0]             board;
  } word_t;

  // Word with its timestamp extended by the wrap count.
  typedef struct packed {
    logic [ExtW-1:0]               ext;
    logic [3:0][SampleW-1:0]       samples;
    logic [ChanW-1:0]              chan;
    logic [BoardW-1:0]             board;
  } ext_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/adc_word_unpack_timestamp_unwrap_core.sv =====
// Digitiser word unpacker with per board and channel timestamp unwrapping.
// A word passes the input register, word buffer and output register before
// its first beat shows, and goes out as four beats; the buffer takes the next
// word in the cycle its last beat is sent. Dropped words go at one per cycle.
// Reset: asynchronous, active low; clears all unwrap state, the filter to all
// channels and the minimum entry count to 300. Depends on adcwu_pkg.
`default_nettype none

module adc_word_unpack_timestamp_unwrap_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input word stream.
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata, lowest bit up: word_hi [15:0], word_lo [79:16].
  input  wire logic [adcwu_pkg::InDataW-1:0]     s_axis_tdata_i,
  // tuser, lowest bit up: board_code [7:0], channel [10:8].
  input  wire logic [adcwu_pkg::InUserW-1:0]     s_axis_tuser_i,
  // Sample stream.
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // tdata, lowest bit up: sample_time [60:0], sample_value [73:61], zeros above.
  output logic [adcwu_pkg::OutDataW-1:0]         m_axis_tdata_o,
  // tuser, lowest bit up: out_channel [2:0], out_board [4:3].
  output logic [adcwu_pkg::OutUserW-1:0]         m_axis_tuser_o,
  output logic                                   m_axis_tlast_o,
  // Configuration write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [adcwu_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [adcwu_pkg::CfgDataW-1:0]    cfg_data_i
);
  import adcwu_pkg::*;

  // Configuration registers. Indexes past the register list are ignored.
  logic [FilterW-1:0] chan_filter_q;
  logic [EntryW-1:0]  min_entries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_filter_q <= FilterAll;
      min_entries_q <= MinEntriesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegChanFilter: chan_filter_q <= cfg_data_i[FilterW-1:0];
        RegMinEntries: min_entries_q <= cfg_data_i[EntryW-1:0];
        default: ;
      endcase
    end
  end

  // Input register. It moves on when its word is dropped or when the word
  // buffer can take it, so a new beat is accepted in the same cycle.
  logic              in_valid_q;
  logic [CodeW-1:0]  code_q;
  logic [ChanW-1:0]  chan_q;
  logic [15:0]       hi_q;
  logic [63:0]       lo_q;

  word_t             word;
  logic              pass;
  ext_word_t         ext_word;
  logic              buf_ready;
  logic              upd;
  logic              advance;

  assign upd             = in_valid_q && pass && buf_ready;
  assign advance         = in_valid_q && (!pass || buf_ready);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      hi_q   <= s_axis_tdata_i[15:0];
      lo_q   <= s_axis_tdata_i[79:16];
      code_q <= s_axis_tuser_i[CodeW-1:0];
      chan_q <= s_axis_tuser_i[CodeW +: ChanW];
    end
  end

  adcwu_unpack u_unpack (
    .board_code_i  (code_q),
    .channel_i     (chan_q),
    .word_hi_i     (hi_q),
    .word_lo_i     (lo_q),
    .chan_filter_i (chan_filter_q),
    .word_o        (word),
    .pass_o        (pass)
  );

  // The slot is read and written back in the cycle the word moves on, so a
  // following word for the same slot already sees the update.
  adcwu_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_i         (upd),
    .word_i        (word),
    .min_entries_i (min_entries_q),
    .ext_word_o    (ext_word)
  );

  adcwu_serial u_serial (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (upd),
    .word_i          (ext_word),
    .ready_o         (buf_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/adcwu_unpack.sv =====
// Field extraction, board decoding and channel filtering for one word.
// Purely combinational; depends on adcwu_pkg.
`default_nettype none

module adcwu_unpack (
  input  wire logic [adcwu_pkg::CodeW-1:0]   board_code_i,
  input  wire logic [adcwu_pkg::ChanW-1:0]   channel_i,
  input  wire logic [15:0]                   word_hi_i,
  input  wire logic [63:0]                   word_lo_i,
  input  wire logic [adcwu_pkg::FilterW-1:0] chan_filter_i,
  output adcwu_pkg::word_t                   word_o,
  output logic                               pass_o
);
  import adcwu_pkg::*;

  logic              known;
  logic [BoardW-1:0] board_idx;
  logic              in_range;
  logic              filt_ok;

  always_comb begin
    known     = 1'b1;
    board_idx = BoardIdx16;
    unique case (board_code_i)
      BoardCode16:  board_idx = BoardIdx16;
      BoardCode64:  board_idx = BoardIdx64;
      BoardCode128: board_idx = BoardIdx128;
      default:      known     = 1'b0;
    endcase
  end

  assign in_range = (int'(board_idx) < NumBoards) && (int'(channel_i) < NumChannels);
  // Filter codes with the sign bit set, other than all ones, match no channel.
  assign filt_ok  = (chan_filter_i == FilterAll) ||
                    (chan_filter_i == FilterW'(channel_i));
  assign pass_o   = known && in_range && filt_ok;

  always_comb begin
    word_o.stamp = {word_hi_i, word_lo_i[63:52]};
    for (int k = 0; k < 4; k++) begin
      word_o.samples[k] = {word_lo_i[48+k], word_lo_i[12*k +: 12]};
    end
    word_o.chan  = channel_i;
    word_o.board = board_idx;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/adcwu_state.sv =====
// Per board and channel unwrap state: wrap count, previous stamp, entry count.
// Reads one slot per word and registers its update; depends on adcwu_pkg.
`default_nettype none

module adcwu_state (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          upd_i,
  input  wire adcwu_pkg::word_t              word_i,
  input  wire logic [adcwu_pkg::EntryW-1:0]  min_entries_i,
  output adcwu_pkg::ext_word_t               ext_word_o
);
  import adcwu_pkg::*;

  logic [WrapW-1:0]  wrap_q  [SlotCount];
  logic [StampW-1:0] prev_q  [SlotCount];
  logic [EntryW-1:0] entry_q [SlotCount];

  logic [SlotW-1:0]  slot;
  logic [WrapW-1:0]  wrap_d;
  logic [EntryW-1:0] entry_inc;
  logic [EntryW-1:0] entry_d;
  logic [StampW-1:0] prev_rd;
  logic              wrapped;

  assign slot = SlotW'(int'(word_i.board) * NumChannels + int'(word_i.chan));

  always_comb begin
    prev_rd   = prev_q[slot];
    entry_inc = (entry_q[slot] == EntryMax) ? entry_q[slot] : entry_q[slot] + 1'b1;
    wrapped   = (word_i.stamp < prev_rd) && ((prev_rd - word_i.stamp) > WrapJump) &&
                (entry_inc > min_entries_i);
    wrap_d    = wrap_q[slot];
    entry_d   = entry_inc;
    if (wrapped) begin
      entry_d = '0;
      if (wrap_q[slot] != WrapMax) begin
        wrap_d = wrap_q[slot] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SlotCount; s++) begin
        wrap_q[s]  <= '0;
        prev_q[s]  <= '0;
        entry_q[s] <= '0;
      end
    end else if (upd_i) begin
      wrap_q[slot]  <= wrap_d;
      prev_q[slot]  <= word_i.stamp;
      entry_q[slot] <= entry_d;
    end
  end

  assign ext_word_o.ext     = {wrap_d, word_i.stamp};
  assign ext_word_o.samples = word_i.samples;
  assign ext_word_o.chan    = word_i.chan;
  assign ext_word_o.board   = word_i.board;

endmodule

`default_nettype wire

// ===== hw/rtl/adcwu_serial.sv =====
// Word buffer and output register: sends the four samples of a word as beats.
// Scales the sample time by 30 for the 128 board; depends on adcwu_pkg.
`default_nettype none

module adcwu_serial (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire adcwu_pkg::ext_word_t            word_i,
  output logic                                 ready_o,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [adcwu_pkg::OutDataW-1:0]       m_axis_tdata_o,
  output logic [adcwu_pkg::OutUserW-1:0]       m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);
  import adcwu_pkg::*;

  logic                buf_valid_q;
  ext_word_t           buf_q;
  logic [1:0]          beat_q;

  logic                out_valid_q;
  logic [TimeW-1:0]    time_q;
  logic [SampleW-1:0]  value_q;
  logic [ChanW-1:0]    chan_q;
  logic [BoardW-1:0]   board_q;
  logic                last_q;

  logic                out_free;
  logic                emit;
  logic [TimeW-1:0]    t16;
  logic [TimeW-1:0]    t30;
  logic [TimeW-1:0]    time_d;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign emit     = buf_valid_q && out_free;
  assign ready_o  = !buf_valid_q || (emit && (beat_q == BeatLast));

  // The beat number gives the offsets 0, 4, 8 and 12 below the scaled stamp.
  assign t16    = TimeW'({buf_q.ext, beat_q, 2'b00});
  assign t30    = (t16 << 5) - (t16 << 1);
  assign time_d = (buf_q.board == BoardIdx128) ? t30 : t16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        beat_q <= beat_q + 1'b1;
        if (beat_q == BeatLast) begin
          buf_valid_q <= 1'b0;
        end
      end
      if (load_i) begin
        buf_valid_q <= 1'b1;
        beat_q      <= '0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= word_i;
    end
    if (emit) begin
      time_q  <= time_d;
      value_q <= buf_q.samples[beat_q];
      chan_q  <= buf_q.chan;
      board_q <= buf_q.board;
      last_q  <= (beat_q == BeatLast);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'({value_q, time_q});
  assign m_axis_tuser_o  = {board_q, chan_q};
  assign m_axis_tlast_o  = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/adcwu_checker.sv =====
// Port-level checks for the digitiser word unpacker, bound to its top level.
// Depends on adcwu_pkg.
`default_nettype none

module adcwu_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [adcwu_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic [adcwu_pkg::OutUserW-1:0] m_axis_tuser_o,
  input wire logic                           m_axis_tlast_o
);
  import adcwu_pkg::*;

  // A stalled beat keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat changed while stalled");

  // The beats of a word follow one another without a gap.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("gap inside the beats of one word");

  // Within a word the source does not change.
  a_same_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
    m_axis_tuser_o == $past(m_axis_tuser_o))
    else $error("source changed inside a word");

  // Unscaled boards place the last sample twelve ticks after the stamp.
  a_last_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && (m_axis_tuser_o[4:3] != BoardIdx128) |->
    m_axis_tdata_o[3:0] == 4'd12)
    else $error("last beat time offset wrong");

endmodule

bind adc_word_unpack_timestamp_unwrap_core adcwu_checker u_adcwu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// ===== dv/adcwu_sample_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the digitiser word unpacker: follows the configuration port,
// predicts the four sample beats of every accepted word and compares them with
// the output stream. Depends on adcwu_pkg only.
module adcwu_sample_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  input  logic                                s_tready_i,
  input  logic [adcwu_pkg::InDataW-1:0]       s_tdata_i,
  input  logic [adcwu_pkg::InUserW-1:0]       s_tuser_i,
  input  logic                                m_tvalid_i,
  input  logic                                m_tready_i,
  input  logic [adcwu_pkg::OutDataW-1:0]      m_tdata_i,
  input  logic [adcwu_pkg::OutUserW-1:0]      m_tuser_i,
  input  logic                                m_tlast_i,
  input  logic                                cfg_we_i,
  input  logic [adcwu_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [adcwu_pkg::CfgDataW-1:0]      cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import adcwu_pkg::*;

  localparam int RawW        = 12;
  localparam int OverflowLsb = 48;
  localparam int BeatStep    = 4;
  localparam logic [63:0] Board128Scale = 64'd30;

  typedef struct packed {
    logic [TimeW-1:0]   stime;
    logic [SampleW-1:0] value;
    logic [ChanW-1:0]   chan;
    logic [BoardW-1:0]  board;
    logic               last;
  } sample_t;

  sample_t pending_samples[$];

  logic [FilterW-1:0] chan_filter;
  logic [EntryW-1:0]  min_entries;
  logic [WrapW-1:0]   wrap_cnt   [SlotCount];
  logic [StampW-1:0]  prev_stamp [SlotCount];
  logic [EntryW-1:0]  entry_cnt  [SlotCount];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Unpacks one word, extends its stamp for its board and channel and queues
  // the four sample beats A1, B1, A0, B0.
  task automatic unpack_and_unwrap(input logic [CodeW-1:0] code,
                                   input logic [ChanW-1:0] chan,
                                   input logic [15:0] hi, input logic [63:0] lo);
    logic [BoardW-1:0] bidx;
    logic [StampW-1:0] stamp;
    logic [ExtW-1:0]   ext;
    logic [63:0]       stamp_time;
    sample_t           beat;
    int                slot;
    case (code)
      BoardCode16:  bidx = BoardIdx16;
      BoardCode64:  bidx = BoardIdx64;
      BoardCode128: bidx = BoardIdx128;
      default:      return;
    endcase
    if (chan_filter != FilterAll && {1'b0, chan} != chan_filter) return;
    slot  = int'(bidx) * NumChannels + int'(chan);
    stamp = {hi, lo[63:52]};
    if (entry_cnt[slot] != EntryMax) entry_cnt[slot]++;
    if (stamp < prev_stamp[slot] && (prev_stamp[slot] - stamp) > WrapJump &&
        entry_cnt[slot] > min_entries) begin
      entry_cnt[slot] = '0;
      if (wrap_cnt[slot] != WrapMax) wrap_cnt[slot]++;
    end
    ext = {wrap_cnt[slot], stamp};
    for (int k = 0; k < 4; k++) begin
      stamp_time = (64'(ext) << 4) + 64'(BeatStep * k);
      if (code == BoardCode128) stamp_time = stamp_time * Board128Scale;
      beat.stime = stamp_time[TimeW-1:0];
      beat.value = {lo[OverflowLsb + k], lo[RawW*k +: RawW]};
      beat.chan  = chan;
      beat.board = bidx;
      beat.last  = (k == 3);
      pending_samples = {pending_samples, beat};
    end
    prev_stamp[slot] = stamp;
  endtask

  task automatic check_sample();
    sample_t want;
    if (pending_samples.size() == 0) begin
      report_mismatch("sample beat with nothing expected", 64'(m_tdata_i[TimeW-1:0]), '0);
      return;
    end
    want = pending_samples.pop_front();
    if (m_tdata_i[TimeW-1:0] != want.stime)
      report_mismatch("sample_time", 64'(m_tdata_i[TimeW-1:0]), 64'(want.stime));
    if (m_tdata_i[TimeW +: SampleW] != want.value)
      report_mismatch("sample_value", 64'(m_tdata_i[TimeW +: SampleW]), 64'(want.value));
    if (m_tdata_i[OutDataW-1:TimeW+SampleW] != '0)
      report_mismatch("tdata padding", 64'(m_tdata_i[OutDataW-1:TimeW+SampleW]), '0);
    if (m_tuser_i[ChanW-1:0] != want.chan)
      report_mismatch("out_channel", 64'(m_tuser_i[ChanW-1:0]), 64'(want.chan));
    if (m_tuser_i[ChanW +: BoardW] != want.board)
      report_mismatch("out_board", 64'(m_tuser_i[ChanW +: BoardW]), 64'(want.board));
    if (m_tlast_i != want.last)
      report_mismatch("last", 64'(m_tlast_i), 64'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_filter = FilterAll;
      min_entries = MinEntriesReset;
      for (int i = 0; i < SlotCount; i++) begin
        wrap_cnt[i]   = '0;
        prev_stamp[i] = '0;
        entry_cnt[i]  = '0;
      end
      pending_samples.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegChanFilter) chan_filter = cfg_data_i[FilterW-1:0];
        else if (cfg_idx_i == RegMinEntries) min_entries = cfg_data_i[EntryW-1:0];
      end
      if (s_tvalid_i && s_tready_i)
        unpack_and_unwrap(s_tuser_i[CodeW-1:0], s_tuser_i[CodeW +: ChanW],
                          s_tdata_i[15:0], s_tdata_i[InDataW-1:16]);
      if (m_tvalid_i && m_tready_i) check_sample();
    end
    pending_o = pending_samples.size();
  end

endmodule

// ===== dv/adc_word_unpack_timestamp_unwrap_core_tb.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the digitiser word unpacker: clock, reset, word
// stimulus, configuration writes and the verdict. Depends on adcwu_pkg, the
// core and adcwu_sample_checker.
module adc_word_unpack_timestamp_unwrap_core_tb;
  import adcwu_pkg::*;

  localparam int ResetCycles = 7;
  // A word passes the input register, word buffer and output register; dropped
  // words may still be in flight when the last expected beat has gone.
  localparam int DrainCycles = 12;
  localparam int RandomWords = 114;
  localparam int PayloadW    = InDataW - StampW;
  // Writes to these indexes must leave both registers alone.
  localparam logic [CfgIdxW-1:0] RegSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareHi = CfgIdxW'(3);
  // The most negative filter value: no channel can match it.
  localparam logic [FilterW-1:0] FilterNone = 4'b1000;
  // Board codes the block must drop.
  localparam logic [CodeW-1:0] CodeZero    = 8'h00;
  localparam logic [CodeW-1:0] CodeAllOnes = 8'hFF;
  localparam logic [CodeW-1:0] CodeMixed   = BoardCode16 | BoardCode128;
  // Stamp bands: small after a wrap, near the wrap threshold, near the top.
  localparam int unsigned StampLowTop  = 32'h0000_FFFF;
  localparam int unsigned StampMidLo   = 32'h0F30_0000;
  localparam int unsigned StampMidHi   = 32'h0F3F_FFFF;
  localparam int unsigned StampHighLo  = 32'h0F40_0000;
  localparam int unsigned StampHighTop = 32'h0FFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata = '0;
  logic [InUserW-1:0]   s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDataW-1:0]  m_tdata;
  logic [OutUserW-1:0]  m_tuser;
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int src_idle_pct = 32;
  int sink_idle_pct = 60;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adc_word_unpack_timestamp_unwrap_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  adcwu_sample_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The receiver stalls on a fresh random draw every cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Sends one word built from its stamp and the 52 bits below it. Called in
  // the time step of a rising edge; returns in the step of the edge that took
  // the beat, leaving tvalid high so that the next word can follow at once.
  task automatic send_word(input logic [CodeW-1:0] code, input logic [ChanW-1:0] chan,
                           input logic [StampW-1:0] stamp,
                           input logic [PayloadW-1:0] payload);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {stamp[11:0], payload, stamp[StampW-1:12]};
    s_tuser  <= {chan, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Holds the input back until every expected beat has come out, then gives
  // any dropped word still inside the block time to leave.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One register write; the extra edge keeps write enable from being lowered
  // and raised in one time step when writes come back to back.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends the given number of random words, mostly for the three known boards.
  // Stamps are drawn from bands that make large backward jumps common, some of
  // them close to the wrap threshold.
  task automatic send_random(input int count);
    logic [CodeW-1:0]   code;
    logic [ChanW-1:0]   chan;
    logic [StampW-1:0]  stamp;
    logic [PayloadW-1:0] payload;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(9);
      if (pick == 0) code = CodeW'($urandom_range(255));
      else if (pick <= 3) code = BoardCode16;
      else if (pick <= 6) code = BoardCode64;
      else code = BoardCode128;
      chan = ChanW'($urandom_range(NumChannels - 1));
      case ($urandom_range(3))
        0: stamp = StampW'($urandom_range(StampLowTop));
        1: stamp = StampW'($urandom_range(StampMidHi, StampMidLo));
        2: stamp = StampW'($urandom_range(StampHighTop, StampHighLo));
        default: stamp = StampW'($urandom);
      endcase
      payload = PayloadW'({$urandom, $urandom});
      send_word(code, chan, stamp, payload);
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words with the reset configuration: an all-zero word on board 16,
    // all-one words on boards 64 and 128, then codes that must be dropped.
    send_word(BoardCode16, 3'd0, '0, '0);
    send_word(BoardCode64, 3'd7, '1, '1);
    send_word(BoardCode128, 3'd3, '1, '1);
    send_word(CodeZero, 3'd1, '1, '1);
    send_word(CodeAllOnes, 3'd2, '1, '1);
    send_word(CodeMixed, 3'd4, '1, '1);
    // A full backward jump after only a few words is not a wrap yet.
    send_word(BoardCode16, 3'd0, '1, PayloadW'({$urandom, $urandom}));
    send_word(BoardCode16, 3'd0, '0, PayloadW'({$urandom, $urandom}));

    // With no minimum entry count the wrap threshold itself is probed: a jump
    // of exactly the threshold is no wrap, one more is, an equal stamp is not.
    wait_drained();
    write_reg(RegMinEntries, '0);
    send_word(BoardCode16, 3'd2, WrapJump, PayloadW'({$urandom, $urandom}));
    send_word(BoardCode16, 3'd2, '0, PayloadW'({$urandom, $urandom}));
    send_word(BoardCode16, 3'd2, WrapJump + 1'b1, PayloadW'({$urandom, $urandom}));
    send_word(BoardCode16, 3'd2, '0, PayloadW'({$urandom, $urandom}));
    send_word(BoardCode16, 3'd2, '0, PayloadW'({$urandom, $urandom}));
    send_word(BoardCode128, 3'd6, '1, PayloadW'({$urandom, $urandom}));
    send_word(BoardCode128, 3'd6, '0, PayloadW'({$urandom, $urandom}));

    // Channel filter: one channel passes, then a negative value that lets
    // nothing through. Writes to the spare indexes must not reopen it.
    wait_drained();
    write_reg(RegChanFilter, CfgDataW'(5));
    send_word(BoardCode64, 3'd5, StampW'($urandom), PayloadW'({$urandom, $urandom}));
    send_word(BoardCode64, 3'd4, StampW'($urandom), PayloadW'({$urandom, $urandom}));
    wait_drained();
    write_reg(RegChanFilter, CfgDataW'(FilterNone));
    write_reg(RegSpareLo, '1);
    write_reg(RegSpareHi, '1);
    send_word(BoardCode16, 3'd0, StampW'($urandom), PayloadW'({$urandom, $urandom}));
    wait_drained();
    write_reg(RegChanFilter, CfgDataW'(7));
    send_word(BoardCode128, 3'd7, StampW'($urandom), PayloadW'({$urandom, $urandom}));

    // Random phase one: wraps come easily, sender idles less than receiver.
    wait_drained();
    write_reg(RegChanFilter, CfgDataW'(FilterAll));
    write_reg(RegMinEntries, CfgDataW'(2));
    send_random(RandomWords);

    // Random phase two: no wrap can be accepted, one random channel passes,
    // and the idling is swapped round.
    wait_drained();
    write_reg(RegMinEntries, EntryMax);
    write_reg(RegChanFilter, CfgDataW'($urandom_range(NumChannels - 1)));
    src_idle_pct  = 60;
    sink_idle_pct = 32;
    send_random(RandomWords);

    // Random phase three: every backward jump past the threshold wraps, and
    // neither side idles.
    wait_drained();
    write_reg(RegChanFilter, CfgDataW'(FilterAll));
    write_reg(RegMinEntries, '0);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_random(RandomWords);

    wait_drained();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: the slowest correct run takes well under a tenth of a millisecond.
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
